FILE: rtl/core/telegram_deframer_crc8_check_top_assert.svh
// ----------------------------------------------------------------------------
// telegram deframer assertion macros
// clocked property checks that drop out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef TELEGRAM_DEFRAMER_CRC8_CHECK_TOP_ASSERT_SVH
`define TELEGRAM_DEFRAMER_CRC8_CHECK_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// checked property, masked while reset is high
`define TDC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tdc assertion failed");

// checked property, live during reset as well
`define TDC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("tdc assertion failed");

`else

`define TDC_ASSERT(lbl, clk, rst, prop)
`define TDC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: rtl/core/tdc_pkg.sv
// ----------------------------------------------------------------------------
// tdc_pkg
// shared types, constants and the crc-8 byte step of the telegram deframer
// ----------------------------------------------------------------------------
package tdc_pkg;

   localparam int MAX_FRAME_BYTES_DEF = 64;

   localparam int BYTE_W  = 8;
   localparam int IDX_W   = 6;
   localparam int CNT_W   = 6;
   localparam int KIND_W  = 3;

   localparam logic [7:0] CRC_POLY   = 8'h5D;
   localparam logic [7:0] CRC_START  = 8'hFF;
   localparam logic [7:0] START_MARK = 8'h53;   // 'S'
   localparam logic [7:0] END_MARK   = 8'h45;   // 'E'
   localparam logic [7:0] LEN_MIN    = 8'd4;    // length, node, command and crc bytes

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_LEN  = 3'd1,
      PH_NODE = 3'd2,
      PH_CMD  = 3'd3,
      PH_DATA = 3'd4,
      PH_CRC  = 3'd5,
      PH_END  = 3'd6
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA       = 3'd0,
      KIND_OK         = 3'd1,
      KIND_BAD_LEN    = 3'd2,
      KIND_BAD_END    = 3'd3,
      KIND_BAD_CRC    = 3'd4,
      KIND_LINE_ERROR = 3'd5
   } kind_type;

   typedef struct packed {
      logic                  valid;
      kind_type              kind;
      logic [BYTE_W-1:0]     node_number;
      logic [BYTE_W-1:0]     command_byte;
      logic [BYTE_W-1:0]     data_byte;
      logic [IDX_W-1:0]      data_index;
      logic [CNT_W-1:0]      data_count;
   } result_type;

   // reflected crc-8, one byte, lsb first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/tdc_parser.sv
// ----------------------------------------------------------------------------
// tdc_parser
// telegram phase machine, crc accumulator and per-word result decode
// ----------------------------------------------------------------------------
module tdc_parser #(
   parameter int MAX_FRAME_BYTES = tdc_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           in_byte,
   input  logic                 in_err,
   output tdc_pkg::result_type  result
);

   localparam int         FL_W    = $clog2(MAX_FRAME_BYTES);
   localparam logic [8:0] LEN_MAX = 9'(MAX_FRAME_BYTES - 2);

   tdc_pkg::phase_type phase_ff, phase_in;
   logic [FL_W-1:0]    len_ff, len_in;
   logic [FL_W-1:0]    pos_ff, pos_in;
   logic [7:0]         crc_ff, crc_in;
   logic [7:0]         node_ff, node_in;
   logic [7:0]         cmd_ff, cmd_in;

   logic               len_ok;
   logic [FL_W:0]      pos_inc;
   logic               last_data;
   logic [7:0]         crc_step;

   assign len_ok    = (in_byte >= tdc_pkg::LEN_MIN) && ({1'b0, in_byte} <= LEN_MAX);
   assign pos_inc   = {1'b0, pos_ff} + (FL_W+1)'(1);
   assign last_data = pos_inc >= {1'b0, len_ff};
   assign crc_step  = tdc_pkg::crc8_byte(crc_ff, in_byte);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (phase_ff == tdc_pkg::PH_HUNT) begin
            if (!in_err && in_byte == tdc_pkg::START_MARK) begin
               phase_in = tdc_pkg::PH_LEN;
            end
         end else if (in_err) begin
            phase_in = tdc_pkg::PH_HUNT;
         end else begin
            unique case (phase_ff)
               tdc_pkg::PH_LEN:  phase_in = len_ok ? tdc_pkg::PH_NODE : tdc_pkg::PH_HUNT;
               tdc_pkg::PH_NODE: phase_in = tdc_pkg::PH_CMD;
               tdc_pkg::PH_CMD:  phase_in = (len_ff == '0) ? tdc_pkg::PH_CRC
                                                            : tdc_pkg::PH_DATA;
               tdc_pkg::PH_DATA: phase_in = last_data ? tdc_pkg::PH_CRC : tdc_pkg::PH_DATA;
               tdc_pkg::PH_CRC:  phase_in = tdc_pkg::PH_END;
               default:          phase_in = tdc_pkg::PH_HUNT;
            endcase
         end
      end
   end

   // datapath updates and result decode
   always_comb begin
      len_in  = len_ff;
      pos_in  = pos_ff;
      crc_in  = crc_ff;
      node_in = node_ff;
      cmd_in  = cmd_ff;

      result              = '0;
      result.kind         = tdc_pkg::KIND_DATA;
      result.node_number  = node_ff;
      result.command_byte = cmd_ff;

      if (step) begin
         if (phase_ff == tdc_pkg::PH_HUNT) begin
            if (!in_err && in_byte == tdc_pkg::START_MARK) begin
               len_in  = '0;
               pos_in  = '0;
               crc_in  = tdc_pkg::CRC_START;
               node_in = '0;
               cmd_in  = '0;
            end
         end else if (in_err) begin
            result.valid      = 1'b1;
            result.kind       = tdc_pkg::KIND_LINE_ERROR;
            result.data_count = tdc_pkg::CNT_W'(pos_ff);
         end else begin
            unique case (phase_ff)
               tdc_pkg::PH_LEN: begin
                  if (len_ok) begin
                     crc_in = crc_step;
                     len_in = FL_W'(in_byte - tdc_pkg::LEN_MIN);
                  end else begin
                     result.valid = 1'b1;
                     result.kind  = tdc_pkg::KIND_BAD_LEN;
                  end
               end
               tdc_pkg::PH_NODE: begin
                  crc_in  = crc_step;
                  node_in = in_byte;
               end
               tdc_pkg::PH_CMD: begin
                  crc_in = crc_step;
                  cmd_in = in_byte;
               end
               tdc_pkg::PH_DATA: begin
                  crc_in            = crc_step;
                  pos_in            = pos_inc[FL_W-1:0];
                  result.valid      = 1'b1;
                  result.data_byte  = in_byte;
                  result.data_index = tdc_pkg::IDX_W'(pos_ff);
                  result.data_count = tdc_pkg::CNT_W'(len_ff);
               end
               tdc_pkg::PH_CRC: begin
                  crc_in = crc_ff ^ in_byte;
               end
               tdc_pkg::PH_END: begin
                  result.valid      = 1'b1;
                  result.data_count = tdc_pkg::CNT_W'(len_ff);
                  if (in_byte != tdc_pkg::END_MARK) begin
                     result.kind = tdc_pkg::KIND_BAD_END;
                  end else if (crc_ff != '0) begin
                     result.kind = tdc_pkg::KIND_BAD_CRC;
                  end else begin
                     result.kind = tdc_pkg::KIND_OK;
                  end
               end
               default: begin
                  result.valid = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tdc_pkg::PH_HUNT;
         len_ff   <= '0;
         pos_ff   <= '0;
         crc_ff   <= tdc_pkg::CRC_START;
         node_ff  <= '0;
         cmd_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         node_ff  <= node_in;
         cmd_ff   <= cmd_in;
      end
   end

endmodule

FILE: rtl/core/telegram_deframer_crc8_check_top.sv
// ----------------------------------------------------------------------------
// telegram_deframer_crc8_check_top
// 'S'-framed, length-driven telegram deframer with reflected crc-8 check
//
//   channel   direction  payload
//   req_      in         tdata: rx_byte   tuser: line_error
//   rsp_      out        tdata: node, command, data, index, count  tuser: kind
//
// one word per cycle is taken and decoded; its result, if any, appears in
// the output register on the next cycle. throughput is set by the single
// input register to result register pass (phase machine plus the unrolled
// crc byte step). a stalled result holds the output register and, once the
// input register is also full, req_tready drops. synchronous reset returns
// the deframer to the start marker hunt and empties both registers.
// ----------------------------------------------------------------------------
`include "telegram_deframer_crc8_check_top_assert.svh"

module telegram_deframer_crc8_check_top #(
   parameter int MAX_FRAME_BYTES = tdc_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // [7:0] rx_byte
   input  logic         req_tuser,    // [0] line_error

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,    // [7:0] node_number, [15:8] command_byte,
                                      // [23:16] data_byte, [29:24] data_index,
                                      // [35:30] data_count, [39:36] zero
   output logic [2:0]   rsp_tuser     // [2:0] kind
);

   // input register
   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_err_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   tdc_pkg::result_type rsp_ff;

   tdc_pkg::result_type res;
   logic                fire;     // word in the input register is decoded this cycle
   logic                take;     // new word enters the input register

   // the decoded word moves on whenever the result register is free or draining
   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign take       = req_tvalid && req_tready;

   assign in_valid_in = take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire && res.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   tdc_parser #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (fire),
      .in_byte (in_byte_ff),
      .in_err  (in_err_ff),
      .result  (res)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_tdata;
         in_err_ff  <= req_tuser;
      end
      if (fire && res.valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {4'b0000,
                        rsp_ff.data_count,
                        rsp_ff.data_index,
                        rsp_ff.data_byte,
                        rsp_ff.command_byte,
                        rsp_ff.node_number};

   // a held word is never overwritten by a new one
   `TDC_ASSERT(a_in_hold, clock, reset, in_valid_ff && !fire |-> !req_tready)
   // a decoded result always lands in the output register
   `TDC_ASSERT(a_rsp_load, clock, reset, fire && res.valid |=> rsp_tvalid)
   // only defined kinds leave the block
   `TDC_ASSERT(a_kind_range, clock, reset, rsp_tvalid |-> rsp_tuser <= tdc_pkg::KIND_LINE_ERROR)
   // nothing is decoded while reset holds the registers empty
   `TDC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !in_valid_ff && !rsp_tvalid)

endmodule

FILE: tb/telegram_deframer_crc8_check_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// telegram_deframer_crc8_check_top_test
// feeds serial bytes into the deframer, first from a short table of frames
// and corner cases, then as random telegrams (mostly well formed, some with
// bad lengths, crc or end markers, line errors and noise). a local model of
// the deframer predicts every result word, and each word leaving the block
// is checked against the oldest prediction. both sides stall at random.
// ----------------------------------------------------------------------------
module telegram_deframer_crc8_check_top_test;

   localparam int FRAME_MAX    = tdc_pkg::MAX_FRAME_BYTES_DEF;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_WORDS = 1950;

   // one result word as the block reports it
   typedef struct packed {
      tdc_pkg::kind_type kind;
      logic [7:0]        node_number;
      logic [7:0]        command_byte;
      logic [7:0]        data_byte;
      logic [5:0]        data_index;
      logic [5:0]        data_count;
   } deframe_result_type;

   // how the byte of a row is formed when it is sent
   typedef enum logic [1:0] {
      BYTE_AS_IS  = 2'd0,   // send rx_byte unchanged
      CRC_GOOD    = 2'd1,   // send the crc that makes the frame check pass
      CRC_FLIPPED = 2'd2    // send the good crc with its lowest bit inverted
   } byte_pick_type;

   // one input word, with an optional result typed in by hand
   typedef struct packed {
      logic [7:0]         rx_byte;
      logic               line_error;
      byte_pick_type      pick;
      logic               typed;
      deframe_result_type want;
   } stim_row_type;

   localparam deframe_result_type NO_RESULT =
      '{tdc_pkg::KIND_DATA, 8'h00, 8'h00, 8'h00, 6'd0, 6'd0};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'h00;    // [7:0] rx_byte
   logic         req_tuser = 1'b0;     // [0] line_error
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;            // [7:0] node_number, [15:8] command_byte,
                                       // [23:16] data_byte, [29:24] data_index,
                                       // [35:30] data_count, [39:36] zero
   logic [2:0]   rsp_tuser;            // [2:0] kind

   // local copy of the deframer state
   tdc_pkg::phase_type rx_phase    = tdc_pkg::PH_HUNT;
   logic [5:0]         payload_len = 6'd0;
   logic [5:0]         payload_pos = 6'd0;
   logic [7:0]         crc_run     = tdc_pkg::CRC_START;
   logic [7:0]         frame_node  = 8'h00;
   logic [7:0]         frame_cmd   = 8'h00;

   deframe_result_type pending_results[$];
   int                 fault_count   = 0;
   int                 words_counted = 0;
   int                 cycle_count   = 0;
   bit                 quiet         = 1'b0;   // no stalls on either side while set

   // directed part: corner cases first, then a few complete telegrams
   stim_row_type directed_rows [32] = '{
      // start marker flagged with a line error is ignored while hunting
      '{tdc_pkg::START_MARK, 1'b1, BYTE_AS_IS, 1'b0, NO_RESULT},
      // any other byte is ignored while hunting
      '{tdc_pkg::END_MARK,   1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      // length one below the minimum
      '{tdc_pkg::START_MARK, 1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'h03,               1'b0, BYTE_AS_IS, 1'b1,
        '{tdc_pkg::KIND_BAD_LEN, 8'h00, 8'h00, 8'h00, 6'd0, 6'd0}},
      // length one above the maximum
      '{tdc_pkg::START_MARK, 1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'h3F,               1'b0, BYTE_AS_IS, 1'b1,
        '{tdc_pkg::KIND_BAD_LEN, 8'h00, 8'h00, 8'h00, 6'd0, 6'd0}},
      // largest length byte
      '{tdc_pkg::START_MARK, 1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'hFF,               1'b0, BYTE_AS_IS, 1'b1,
        '{tdc_pkg::KIND_BAD_LEN, 8'h00, 8'h00, 8'h00, 6'd0, 6'd0}},
      // empty payload, good crc, good end marker
      '{tdc_pkg::START_MARK, 1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'h04,               1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'hFF,               1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'h00,               1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'h00,               1'b0, CRC_GOOD,   1'b0, NO_RESULT},
      '{tdc_pkg::END_MARK,   1'b0, BYTE_AS_IS, 1'b1,
        '{tdc_pkg::KIND_OK, 8'hFF, 8'h00, 8'h00, 6'd0, 6'd0}},
      // two payload bytes at the extremes, start marker where the end belongs
      '{tdc_pkg::START_MARK, 1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'h06,               1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'h00,               1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'hFF,               1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'hFF,               1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'h00,               1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'h00,               1'b0, CRC_GOOD,   1'b0, NO_RESULT},
      '{tdc_pkg::START_MARK, 1'b0, BYTE_AS_IS, 1'b1,
        '{tdc_pkg::KIND_BAD_END, 8'h00, 8'hFF, 8'h00, 6'd0, 6'd2}},
      // hunting resumes on the next byte: one payload byte, crc off by a bit
      '{tdc_pkg::START_MARK, 1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'h05,               1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'hAA,               1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'h55,               1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'h12,               1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'h00,               1'b0, CRC_FLIPPED, 1'b0, NO_RESULT},
      '{tdc_pkg::END_MARK,   1'b0, BYTE_AS_IS, 1'b1,
        '{tdc_pkg::KIND_BAD_CRC, 8'hAA, 8'h55, 8'h00, 6'd0, 6'd1}},
      // largest legal length, then a line error on the node byte
      '{tdc_pkg::START_MARK, 1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'h3E,               1'b0, BYTE_AS_IS, 1'b0, NO_RESULT},
      '{8'h01,               1'b1, BYTE_AS_IS, 1'b1,
        '{tdc_pkg::KIND_LINE_ERROR, 8'h00, 8'h00, 8'h00, 6'd0, 6'd0}}
   };

   telegram_deframer_crc8_check_top #(
      .MAX_FRAME_BYTES (FRAME_MAX)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // reflected crc-8, shifted out lsb first
   function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] c;
      c = acc ^ b;
      repeat (8) c = (c >> 1) ^ (c[0] ? tdc_pkg::CRC_POLY : 8'h00);
      return c;
   endfunction

   // one result word as text
   function automatic string result_text(input deframe_result_type r);
      return $sformatf("kind %0d node %02h cmd %02h data %02h idx %0d cnt %0d",
                       r.kind, r.node_number, r.command_byte, r.data_byte,
                       r.data_index, r.data_count);
   endfunction

   // advance the local deframer by one received byte; returns 1 with a result
   function automatic bit deframe_byte(input logic [7:0] b, input logic err,
                                       output deframe_result_type r);
      r = NO_RESULT;
      if (rx_phase == tdc_pkg::PH_HUNT) begin
         // only a clean start marker opens a frame
         if (!err && b == tdc_pkg::START_MARK) begin
            rx_phase    = tdc_pkg::PH_LEN;
            crc_run     = tdc_pkg::CRC_START;
            payload_pos = 6'd0;
            payload_len = 6'd0;
            frame_node  = 8'h00;
            frame_cmd   = 8'h00;
         end
         return 1'b0;
      end
      // a line error inside a frame beats every other check
      if (err) begin
         rx_phase = tdc_pkg::PH_HUNT;
         r = '{tdc_pkg::KIND_LINE_ERROR, frame_node, frame_cmd, 8'h00, 6'd0, payload_pos};
         return 1'b1;
      end
      case (rx_phase)
         tdc_pkg::PH_LEN: begin
            if (b < tdc_pkg::LEN_MIN || int'(b) > FRAME_MAX - 2) begin
               rx_phase = tdc_pkg::PH_HUNT;
               r = '{tdc_pkg::KIND_BAD_LEN, frame_node, frame_cmd, 8'h00, 6'd0, 6'd0};
               return 1'b1;
            end
            crc_run     = crc8_step(crc_run, b);
            payload_len = 6'(b - tdc_pkg::LEN_MIN);
            rx_phase    = tdc_pkg::PH_NODE;
         end
         tdc_pkg::PH_NODE: begin
            crc_run    = crc8_step(crc_run, b);
            frame_node = b;
            rx_phase   = tdc_pkg::PH_CMD;
         end
         tdc_pkg::PH_CMD: begin
            crc_run   = crc8_step(crc_run, b);
            frame_cmd = b;
            // empty payload skips straight to the crc byte
            rx_phase  = (payload_len == 6'd0) ? tdc_pkg::PH_CRC : tdc_pkg::PH_DATA;
         end
         tdc_pkg::PH_DATA: begin
            r = '{tdc_pkg::KIND_DATA, frame_node, frame_cmd, b, payload_pos, payload_len};
            crc_run     = crc8_step(crc_run, b);
            payload_pos = payload_pos + 6'd1;
            if (payload_pos >= payload_len) rx_phase = tdc_pkg::PH_CRC;
            return 1'b1;
         end
         tdc_pkg::PH_CRC: begin
            // zero left behind means the crc matched
            crc_run  = crc_run ^ b;
            rx_phase = tdc_pkg::PH_END;
         end
         tdc_pkg::PH_END: begin
            rx_phase = tdc_pkg::PH_HUNT;
            // a wrong end marker wins over a crc mismatch
            if (b != tdc_pkg::END_MARK)
               r = '{tdc_pkg::KIND_BAD_END, frame_node, frame_cmd, 8'h00, 6'd0,
                     payload_len};
            else if (crc_run != 8'h00)
               r = '{tdc_pkg::KIND_BAD_CRC, frame_node, frame_cmd, 8'h00, 6'd0,
                     payload_len};
            else
               r = '{tdc_pkg::KIND_OK, frame_node, frame_cmd, 8'h00, 6'd0, payload_len};
            return 1'b1;
         end
         default: rx_phase = tdc_pkg::PH_HUNT;
      endcase
      return 1'b0;
   endfunction

   // send one word; called and returning at a falling edge
   task automatic send_word(input stim_row_type row);
      logic [7:0]         b;
      deframe_result_type predicted;
      bit                 has_result;
      b = row.rx_byte;
      if (row.pick == CRC_GOOD)
         b = crc_run;
      else if (row.pick == CRC_FLIPPED)
         b = crc_run ^ 8'h01;
      words_counted++;
      quiet = (words_counted >= 700 && words_counted < 1000);
      while (!quiet && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= row.line_error;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // word taken at this edge
      has_result = deframe_byte(b, row.line_error, predicted);
      if (row.typed)
         pending_results.push_back(row.want);
      else if (has_result)
         pending_results.push_back(predicted);
      @(negedge clock);
   endtask

   // result side back-pressure
   always @(negedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= 19);
   end

   // result checker
   always @(posedge clock) begin
      deframe_result_type got;
      deframe_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{tdc_pkg::kind_type'(rsp_tuser), rsp_tdata[7:0], rsp_tdata[15:8],
                 rsp_tdata[23:16], rsp_tdata[29:24], rsp_tdata[35:30]};
         if (pending_results.size() == 0) begin
            fault_count++;
            $display("%0t: expected no word, actual %s", $time, result_text(got));
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               fault_count++;
               $display("%0t: expected %s, actual %s", $time, result_text(want),
                        result_text(got));
            end
         end
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("telegram_deframer_crc8_check_top: mismatch");
         $finish;
      end
   end

   initial begin
      stim_row_type frame_q[$];
      stim_row_type w;
      int           len;
      int           k;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) send_word(directed_rows[i]);

      // random telegrams, mostly well formed with random content
      while (words_counted < RANDOM_WORDS) begin
         frame_q = {};
         w = '{8'h00, 1'b0, BYTE_AS_IS, 1'b0, NO_RESULT};
         // noise between telegrams, sometimes holding a stray start marker
         if ($urandom_range(99) < 30) begin
            repeat ($urandom_range(3, 1)) begin
               w.rx_byte    = ($urandom_range(9) == 0) ? tdc_pkg::START_MARK : 8'($urandom);
               w.line_error = ($urandom_range(9) == 0);
               frame_q.push_back(w);
            end
         end
         w.line_error = 1'b0;
         w.rx_byte = tdc_pkg::START_MARK;
         frame_q.push_back(w);
         k = $urandom_range(99);
         if (k < 8)
            len = $urandom_range(1) ? $urandom_range(3) : $urandom_range(255, FRAME_MAX - 1);
         else if (k < 70)
            len = $urandom_range(12, 4);
         else if (k < 95)
            len = $urandom_range(40, 13);
         else
            len = $urandom_range(FRAME_MAX - 2, 41);
         w.rx_byte = 8'(len);
         frame_q.push_back(w);
         if (len >= 4 && len <= FRAME_MAX - 2) begin
            // node, command and payload
            repeat (len - 2) begin
               w.rx_byte = 8'($urandom);
               frame_q.push_back(w);
            end
            k = $urandom_range(99);
            w.rx_byte = 8'($urandom);
            w.pick = (k < 80) ? CRC_GOOD : ((k < 90) ? CRC_FLIPPED : BYTE_AS_IS);
            frame_q.push_back(w);
            w.pick = BYTE_AS_IS;
            w.rx_byte = ($urandom_range(99) < 85) ? tdc_pkg::END_MARK : 8'($urandom);
            frame_q.push_back(w);
         end
         if ($urandom_range(99) < 8)
            frame_q[$urandom_range(frame_q.size() - 1)].line_error = 1'b1;
         foreach (frame_q[i]) send_word(frame_q[i]);
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fault_count == 0 && pending_results.size() == 0)
         $display("telegram_deframer_crc8_check_top: match");
      else
         $display("telegram_deframer_crc8_check_top: mismatch");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/tdc_pkg.sv
rtl/core/tdc_parser.sv
rtl/core/telegram_deframer_crc8_check_top.sv
tb/telegram_deframer_crc8_check_top_test.sv
